// ----- rtl/vfc_pkg.sv -----
// ----------------------------------------------------------------------------
// vfc_pkg
// Shared types, codes and constants of the voxel face culler: command codes,
// face direction codes, controller states and the controller/datapath link.
// ----------------------------------------------------------------------------
package vfc_pkg;

    localparam int EDGE_DEF       = 16;
    localparam int LIGHT_BITS_DEF = 8;

    localparam int ID_W      = 16;
    localparam int VARIANT_W = 8;
    localparam int LIGHT_W   = 8;
    localparam int POS_W     = 4;
    localparam int DIR_W     = 3;
    localparam int NUM_DIRS  = 6;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_CULL  = 1'b1;

    localparam logic [DIR_W-1:0] DIR_PY = 3'd0;
    localparam logic [DIR_W-1:0] DIR_NY = 3'd1;
    localparam logic [DIR_W-1:0] DIR_PX = 3'd2;
    localparam logic [DIR_W-1:0] DIR_NX = 3'd3;
    localparam logic [DIR_W-1:0] DIR_PZ = 3'd4;
    localparam logic [DIR_W-1:0] DIR_NZ = 3'd5;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_TAIL,
        S_EMIT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic             capture;    // latch the position, clear the face mask
        logic             wr;         // store the voxel on the input ports
        logic             rd_center;  // read the voxel addressed by the input ports
        logic             rd_nb;      // read the neighbor in direction nb_dir
        logic [DIR_W-1:0] nb_dir;
        logic             eval_ctr;   // latch the center voxel from the read data
        logic             eval_nb;    // test the neighbor read data for transparency
        logic [DIR_W-1:0] eval_dir;
        logic             emit;       // load the next result into the output register
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic in_inside;   // the position on the input ports lies in the chunk
        logic ctr_air;     // the read data holds an air voxel
        logic mask_empty;  // no face left to emit
        logic mask_one;    // exactly one face left to emit
        logic out_free;    // the output register can take a result this cycle
    } t_dp_sts;

    function automatic int dir_dx(input logic [DIR_W-1:0] dir);
        case (dir)
            DIR_PX:  return 1;
            DIR_NX:  return -1;
            default: return 0;
        endcase
    endfunction

    function automatic int dir_dy(input logic [DIR_W-1:0] dir);
        case (dir)
            DIR_PY:  return 1;
            DIR_NY:  return -1;
            default: return 0;
        endcase
    endfunction

    function automatic int dir_dz(input logic [DIR_W-1:0] dir);
        case (dir)
            DIR_PZ:  return 1;
            DIR_NZ:  return -1;
            default: return 0;
        endcase
    endfunction

endpackage

// ----- rtl/vfc_ctrl.sv -----
// ----------------------------------------------------------------------------
// vfc_ctrl
// Controller state machine: sequences the center and neighbor reads of a cull
// request and the emission of its results, and takes voxel writes.
// ----------------------------------------------------------------------------
module vfc_ctrl
    import vfc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_command,
    output logic    o_in_stall,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    t_state           r_state, n_state;
    logic [DIR_W-1:0] r_dir, n_dir;
    logic             accept;

    assign o_in_stall = (r_state != S_IDLE);
    assign accept     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_dir   <= DIR_PY;
        end else begin
            r_state <= n_state;
            r_dir   <= n_dir;
        end
    end

    always_comb begin
        n_state = r_state;
        n_dir   = r_dir;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_command == CMD_WRITE) begin
                        o_cmd.wr = 1'b1;
                    end else begin
                        o_cmd.capture = 1'b1;
                        if (i_sts.in_inside) begin
                            o_cmd.rd_center = 1'b1;
                            n_dir           = DIR_PY;
                            n_state         = S_READ;
                        end else begin
                            n_state = S_EMIT;
                        end
                    end
                end
            end
            S_READ: begin
                // In the first step the read data is the center voxel; after
                // that it is the neighbor read issued in the step before.
                if (r_dir == DIR_PY) begin
                    if (i_sts.ctr_air) begin
                        n_state = S_EMIT;
                    end else begin
                        o_cmd.eval_ctr = 1'b1;
                        o_cmd.rd_nb    = 1'b1;
                        o_cmd.nb_dir   = DIR_PY;
                        n_dir          = DIR_NY;
                    end
                end else begin
                    o_cmd.eval_nb  = 1'b1;
                    o_cmd.eval_dir = DIR_W'(r_dir - 3'd1);
                    o_cmd.rd_nb    = 1'b1;
                    o_cmd.nb_dir   = r_dir;
                    if (r_dir == DIR_NZ) begin
                        n_state = S_TAIL;
                    end else begin
                        n_dir = DIR_W'(r_dir + 3'd1);
                    end
                end
            end
            S_TAIL: begin
                o_cmd.eval_nb  = 1'b1;
                o_cmd.eval_dir = DIR_NZ;
                n_state        = S_EMIT;
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_sts.mask_empty || i_sts.mask_one) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/vfc_datapath.sv -----
// ----------------------------------------------------------------------------
// vfc_datapath
// Voxel memory, address generation, face mask and output register of the
// voxel face culler. Acts on controller commands; i_cfg_we sets the air id.
// ----------------------------------------------------------------------------
module vfc_datapath
    import vfc_pkg::*;
#(
    parameter int EDGE       = EDGE_DEF,
    parameter int LIGHT_BITS = LIGHT_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_dp_cmd              i_cmd,
    output t_dp_sts              o_sts,
    input  logic                 i_cfg_we,
    input  logic [ID_W-1:0]      i_cfg_data,
    input  logic [POS_W-1:0]     i_pos_x,
    input  logic [POS_W-1:0]     i_pos_y,
    input  logic [POS_W-1:0]     i_pos_z,
    input  logic [ID_W-1:0]      i_voxel_id,
    input  logic [VARIANT_W-1:0] i_voxel_variant,
    input  logic [LIGHT_W-1:0]   i_voxel_light,
    input  logic                 i_voxel_solid,
    input  logic                 i_out_stall,
    output logic                 o_out_valid,
    output logic                 o_face_valid,
    output logic [POS_W-1:0]     o_face_x,
    output logic [POS_W-1:0]     o_face_y,
    output logic [POS_W-1:0]     o_face_z,
    output logic [DIR_W-1:0]     o_direction,
    output logic [ID_W-1:0]      o_texture_id,
    output logic [VARIANT_W-1:0] o_face_variant,
    output logic [LIGHT_W-1:0]   o_face_light,
    output logic                 o_last
);

    localparam int DEPTH = EDGE * EDGE * EDGE;
    localparam int AW    = $clog2(DEPTH);
    localparam int MW    = ID_W + VARIANT_W + LIGHT_BITS + 1;

    // Entry layout: id, variant, light, solid flag in the low bit.
    logic [MW-1:0]         r_mem [DEPTH];
    logic [MW-1:0]         r_rd_data;

    logic [ID_W-1:0]       r_air_id;
    logic [POS_W-1:0]      r_pos_x, r_pos_y, r_pos_z;
    logic [ID_W-1:0]       r_ctr_id;
    logic [VARIANT_W-1:0]  r_ctr_variant;
    logic [LIGHT_BITS-1:0] r_ctr_light;
    logic [NUM_DIRS-1:0]   r_mask;
    logic                  r_out_valid;

    logic [AW-1:0]         in_addr, nb_addr, rd_addr;
    logic                  in_inside, nb_inside, eval_outside, transparent;
    logic [DIR_W-1:0]      first_dir;
    logic [NUM_DIRS-1:0]   mask_clr;
    logic                  out_free;
    logic [ID_W-1:0]       rd_id;

    always_comb begin
        int ix, iy, iz;
        ix = int'(i_pos_x);
        iy = int'(i_pos_y);
        iz = int'(i_pos_z);
        in_inside = (ix < EDGE) && (iy < EDGE) && (iz < EDGE);
        in_addr   = AW'((iy * EDGE + ix) * EDGE + iz);
    end

    assign o_sts.in_inside = in_inside;

    // Neighbor to read; an outside neighbor reads the center, and that data
    // is never looked at.
    always_comb begin
        int nx, ny, nz;
        nx        = int'(r_pos_x) + dir_dx(i_cmd.nb_dir);
        ny        = int'(r_pos_y) + dir_dy(i_cmd.nb_dir);
        nz        = int'(r_pos_z) + dir_dz(i_cmd.nb_dir);
        nb_inside = (nx >= 0) && (ny >= 0) && (nz >= 0) &&
                    (nx < EDGE) && (ny < EDGE) && (nz < EDGE);
        if (nb_inside) begin
            nb_addr = AW'((ny * EDGE + nx) * EDGE + nz);
        end else begin
            nb_addr = AW'((int'(r_pos_y) * EDGE + int'(r_pos_x)) * EDGE + int'(r_pos_z));
        end
    end

    always_comb begin
        int ex, ey, ez;
        ex           = int'(r_pos_x) + dir_dx(i_cmd.eval_dir);
        ey           = int'(r_pos_y) + dir_dy(i_cmd.eval_dir);
        ez           = int'(r_pos_z) + dir_dz(i_cmd.eval_dir);
        eval_outside = (ex < 0) || (ey < 0) || (ez < 0) ||
                       (ex >= EDGE) || (ey >= EDGE) || (ez >= EDGE);
    end

    assign rd_addr     = i_cmd.rd_center ? in_addr : nb_addr;
    assign transparent = eval_outside || !r_rd_data[0];
    assign rd_id       = r_rd_data[MW-1 -: ID_W];

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr && in_inside) begin
            r_mem[in_addr] <= {i_voxel_id, i_voxel_variant,
                               LIGHT_BITS'(i_voxel_light), i_voxel_solid};
        end
        if (i_cmd.rd_center || i_cmd.rd_nb) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    assign o_sts.ctr_air = (rd_id == r_air_id);

    // Lowest pending direction is the next face out.
    always_comb begin
        logic found;
        found     = 1'b0;
        first_dir = DIR_PY;
        for (int i = 0; i < NUM_DIRS; i++) begin
            if (!found && r_mask[i]) begin
                first_dir = DIR_W'(i);
                found     = 1'b1;
            end
        end
        mask_clr = r_mask & (r_mask - NUM_DIRS'(1));
    end

    assign o_sts.mask_empty = (r_mask == '0);
    assign o_sts.mask_one   = !o_sts.mask_empty && (mask_clr == '0);
    assign out_free         = !r_out_valid || !i_out_stall;
    assign o_sts.out_free   = out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_air_id    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_air_id <= i_cfg_data;
            end
            if (out_free) begin
                r_out_valid <= i_cmd.emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_pos_x <= i_pos_x;
            r_pos_y <= i_pos_y;
            r_pos_z <= i_pos_z;
            r_mask  <= '0;
        end else if (i_cmd.eval_nb && transparent) begin
            r_mask[i_cmd.eval_dir] <= 1'b1;
        end else if (i_cmd.emit) begin
            r_mask <= mask_clr;
        end
        if (i_cmd.eval_ctr) begin
            r_ctr_id      <= rd_id;
            r_ctr_variant <= r_rd_data[MW-1-ID_W -: VARIANT_W];
            r_ctr_light   <= r_rd_data[LIGHT_BITS:1];
        end
        if (i_cmd.emit) begin
            if (o_sts.mask_empty) begin
                o_face_valid   <= 1'b0;
                o_face_x       <= '0;
                o_face_y       <= '0;
                o_face_z       <= '0;
                o_direction    <= DIR_PY;
                o_texture_id   <= '0;
                o_face_variant <= '0;
                o_face_light   <= '0;
                o_last         <= 1'b1;
            end else begin
                o_face_valid   <= 1'b1;
                o_face_x       <= r_pos_x;
                o_face_y       <= r_pos_y;
                o_face_z       <= r_pos_z;
                o_direction    <= first_dir;
                o_texture_id   <= r_ctr_id;
                o_face_variant <= r_ctr_variant;
                o_face_light   <= LIGHT_W'(r_ctr_light);
                o_last         <= o_sts.mask_one;
            end
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// ----- rtl/voxel_face_culler_core.sv -----
// ----------------------------------------------------------------------------
// voxel_face_culler_core
// Face culling for one cubic chunk of EDGE^3 voxels held in on-chip memory.
//
// Input channel (i_in_valid / o_in_stall): a write command stores one voxel;
// a cull command names one position and yields its visible faces.
// Output channel (o_out_valid / i_out_stall): one result per visible face in
// the order +Y, -Y, +X, -X, +Z, -Z, the final one marked by o_last. An air
// voxel, a fully enclosed voxel or a position outside the chunk gives one
// result with o_face_valid low and o_last high.
// A write leaves the controller idle, so writes stream at one item per cycle.
// A cull reads the center and its six neighbors one after another through the
// single read port of the voxel memory, checking each neighbor as its data
// returns, then emits its results in turn; an air center ends the reads early
// and an outside position goes straight to emission, the input stalled throughout.
// The last result sits in an output register, so the next item is taken while
// it waits. While the receiver stalls, the output register holds its result
// and the block stops emitting. Reset clears the controller, the output valid
// and air_id; the voxel memory is not cleared and must be written first.
// ----------------------------------------------------------------------------
module voxel_face_culler_core
    import vfc_pkg::*;
#(
    parameter int EDGE       = EDGE_DEF,
    parameter int LIGHT_BITS = LIGHT_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [ID_W-1:0]      i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic                 i_command,
    input  logic [POS_W-1:0]     i_pos_x,
    input  logic [POS_W-1:0]     i_pos_y,
    input  logic [POS_W-1:0]     i_pos_z,
    input  logic [ID_W-1:0]      i_voxel_id,
    input  logic [VARIANT_W-1:0] i_voxel_variant,
    input  logic [LIGHT_W-1:0]   i_voxel_light,
    input  logic                 i_voxel_solid,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic                 o_face_valid,
    output logic [POS_W-1:0]     o_face_x,
    output logic [POS_W-1:0]     o_face_y,
    output logic [POS_W-1:0]     o_face_z,
    output logic [DIR_W-1:0]     o_direction,
    output logic [ID_W-1:0]      o_texture_id,
    output logic [VARIANT_W-1:0] o_face_variant,
    output logic [LIGHT_W-1:0]   o_face_light,
    output logic                 o_last
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    vfc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_command  (i_command),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    vfc_datapath #(
        .EDGE       (EDGE),
        .LIGHT_BITS (LIGHT_BITS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .i_pos_x         (i_pos_x),
        .i_pos_y         (i_pos_y),
        .i_pos_z         (i_pos_z),
        .i_voxel_id      (i_voxel_id),
        .i_voxel_variant (i_voxel_variant),
        .i_voxel_light   (i_voxel_light),
        .i_voxel_solid   (i_voxel_solid),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_face_valid    (o_face_valid),
        .o_face_x        (o_face_x),
        .o_face_y        (o_face_y),
        .o_face_z        (o_face_z),
        .o_direction     (o_direction),
        .o_texture_id    (o_texture_id),
        .o_face_variant  (o_face_variant),
        .o_face_light    (o_face_light),
        .o_last          (o_last)
    );

endmodule

// ----- rtl/vfc_checker.sv -----
// ----------------------------------------------------------------------------
// vfc_checker
// Port-level checks of the voxel face culler, bound to the top level.
// ----------------------------------------------------------------------------
module vfc_checker
    import vfc_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_out_stall,
    input logic                 o_out_valid,
    input logic                 o_face_valid,
    input logic [POS_W-1:0]     o_face_x,
    input logic [DIR_W-1:0]     o_direction,
    input logic [ID_W-1:0]      o_texture_id,
    input logic [LIGHT_W-1:0]   o_face_light,
    input logic                 o_last
);

    // No result may be left over from before a reset.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // A request without faces yields exactly one result, so it must close it.
    a_invalid_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_face_valid |-> o_last)
        else $error("invalid result not marked last");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_face_valid |->
            o_direction == DIR_PY && o_texture_id == '0 &&
            o_face_x == '0 && o_face_light == '0)
        else $error("invalid result carries nonzero fields");

    a_dir_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_face_valid |-> o_direction <= DIR_NZ)
        else $error("face direction out of range");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_direction) && $stable(o_last))
        else $error("stalled result changed");

endmodule

bind voxel_face_culler_core vfc_checker u_vfc_checker (.*);
